// ===== rtl/s2da_pkg.sv =====
// Shared constants and types for the signed-to-decimal ASCII unit.
`timescale 1ns / 1ps

package s2da_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 6;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned InDataW   = ((ValueW + 7) / 8) * 8;
  localparam int unsigned OutDataW  = ((CharW + 7) / 8) * 8;
  localparam int unsigned BitCntW   = $clog2(ValueW);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  localparam logic [CharW-1:0] CharZero  = CharW'(48);
  localparam logic [CharW-1:0] CharMinus = CharW'(45);

  // Per-cycle command to every digit cell of the chain.
  typedef struct packed {
    logic clr;     // clear the digit
    logic dabble;  // add-3 correction then shift in the neighbor's carry
    logic move;    // take the lower neighbor's digit (readout toward the top)
  } cell_ctrl_t;

endpackage

// ===== rtl/signed_to_decimal_ascii_unit.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
`timescale 1ns / 1ps

// Usage:
// One signed 32-bit value enters per transfer on the slave stream
// (s_axis_*). Its decimal text leaves on the master stream (m_axis_*), one
// ASCII character per transfer, most significant digit first, with a leading
// minus sign for negative values and tlast on the final character. Leading
// zeros are suppressed; zero gives a single '0'. A run has one to eleven
// characters.
// Operation: the block works on one value at a time. After acceptance the
// magnitude is shifted bit-serially through a chain of ten BCD digit
// cells in 32 steps, the optional minus sign is then emitted, and the
// ten digits are read out of the top of the chain, one per cycle unless
// a receiver stall holds the output, suppressed leading zeros included.
// A new value is taken only after the last character has been
// registered.
// s_axis_tready_o is high only while no value is in progress.
// Reset clears the control state and all digit cells; no output is valid.
// When the receiver stalls, the pending character holds in the output
// register and the readout of the chain waits with it.

module signed_to_decimal_ascii_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave stream: tdata[31:0] = value (signed).
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [s2da_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Master stream: tdata[5:0] = character, tdata[7:6] = zero.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [s2da_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                          m_axis_tlast_o   // last character of the run
);
  import s2da_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSign = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [ValueW-1:0]  mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0] dig_cnt_q, dig_cnt_d;
  logic               started_q, started_d;

  logic               out_valid_q, out_valid_d;
  logic [CharW-1:0]   out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  cell_ctrl_t         ctrl;
  logic [NumDigits-1:0] carry;
  logic [DigitW-1:0]    digit [NumDigits];
  logic [DigitW-1:0]    top_digit;

  logic in_fire;
  logic slot_free;
  logic [ValueW-1:0] raw;

  assign raw       = s_axis_tdata_i[ValueW-1:0];
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign top_digit = digit[NumDigits-1];

  // The digit chain: carries climb toward the top during conversion, and
  // digits move up one cell per readout step so the top cell is always the
  // next digit to emit.
  for (genvar g = 0; g < NumDigits; g++) begin : g_cell
    logic             bit_in;
    logic [DigitW-1:0] digit_in;
    if (g == 0) begin : g_first
      assign bit_in   = mag_q[ValueW-1];
      assign digit_in = '0;
    end else begin : g_rest
      assign bit_in   = carry[g-1];
      assign digit_in = digit[g-1];
    end
    s2da_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (digit_in),
      .carry_o (carry[g]),
      .digit_o (digit[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    started_d   = started_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    ctrl        = '0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          neg_d     = raw[ValueW-1];
          // Unsigned negation, so the most negative value yields 2^31.
          mag_d     = raw[ValueW-1] ? (ValueW'(0) - raw) : raw;
          bit_cnt_d = '0;
          ctrl.clr  = 1'b1;
          state_d   = StConv;
        end
      end
      StConv: begin
        ctrl.dabble = 1'b1;
        mag_d       = {mag_q[ValueW-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q + BitCntW'(1);
        if (bit_cnt_q == BitCntW'(ValueW - 1)) begin
          dig_cnt_d = DigCntW'(NumDigits);
          started_d = 1'b0;
          state_d   = neg_q ? StSign : StEmit;
        end
      end
      StSign: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_char_d  = CharMinus;
          out_last_d  = 1'b0;
          state_d     = StEmit;
        end
      end
      StEmit: begin
        if (!started_q && top_digit == '0 && dig_cnt_q != DigCntW'(1)) begin
          // Leading zero: drop it without a transfer.
          ctrl.move = 1'b1;
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end else if (slot_free) begin
          ctrl.move   = 1'b1;
          dig_cnt_d   = dig_cnt_q - DigCntW'(1);
          started_d   = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = CharZero + CharW'(top_digit);
          out_last_d  = (dig_cnt_q == DigCntW'(1));
          if (dig_cnt_q == DigCntW'(1)) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutDataW'(out_char_q);
  assign m_axis_tlast_o  = out_last_q;

  // An accepted value always starts a fresh 32-step conversion.
  a_start_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StConv) && (bit_cnt_q == '0))
    else $error("conversion did not start after an accepted value");

  // The top of the chain must hold a valid BCD digit throughout readout.
  a_bcd_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (top_digit <= DigitW'(9)))
    else $error("non-BCD digit reached the top of the chain");

  // Readout never runs past the last digit.
  a_emit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (dig_cnt_q != '0))
    else $error("digit readout ran past the chain");

  // A minus sign is never the final character of a run.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_char_q == CharMinus)) |-> !m_axis_tlast_o)
    else $error("minus sign flagged as last character");

  // Every other character emitted is a decimal digit.
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (out_char_q != CharMinus)) |->
      ((out_char_q >= CharZero) && (out_char_q <= CharZero + CharW'(9))))
    else $error("emitted character is not a digit");

endmodule

// ===== rtl/s2da_cell.sv =====
// One BCD digit cell of the double-dabble chain.
`timescale 1ns / 1ps

module s2da_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  s2da_pkg::cell_ctrl_t      ctrl_i,
  input  logic                      bit_i,
  input  logic [s2da_pkg::DigitW-1:0] digit_i,
  output logic                      carry_o,
  output logic [s2da_pkg::DigitW-1:0] digit_o
);
  import s2da_pkg::*;

  logic [DigitW-1:0] digit_q, digit_d;
  logic [DigitW-1:0] digit_adj;

  // Values of five or more get three added so that the shift carries at ten.
  assign digit_adj = (digit_q >= DigitW'(5)) ? digit_q + DigitW'(3) : digit_q;
  assign carry_o   = digit_adj[DigitW-1];
  assign digit_o   = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {digit_adj[DigitW-2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ===== tb/s2da_text_checker.sv =====
// Scoreboard that predicts and checks the decimal text of every accepted value.
`timescale 1ns / 1ps

module s2da_text_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  input  logic                          s_axis_tready_i,
  input  logic [s2da_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          m_axis_tvalid_i,
  input  logic                          m_axis_tready_i,
  input  logic [s2da_pkg::OutDataW-1:0] m_axis_tdata_i,
  input  logic                          m_axis_tlast_i,
  output int                            fail_count_o,
  output int                            chars_pending_o
);
  import s2da_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             is_last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;
  int         fail_count = 0;
  int         reported   = 0;

  // Decimal rendering of one value: optional minus, then the magnitude most
  // significant digit first, without leading zeros.
  function automatic void render_decimal(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] mag;
    logic [DigitW-1:0] digit_buf [NumDigits];
    int                nd;
    text_char_t        ch;
    nd = 0;
    if (value[ValueW-1]) begin
      ch.code    = CharMinus;
      ch.is_last = 1'b0;
      expected_text.push_back(ch);
      mag = -value;
    end else begin
      mag = value;
    end
    if (mag == '0) begin
      digit_buf[0] = '0;
      nd = 1;
    end else begin
      while (mag != '0) begin
        digit_buf[nd] = DigitW'(mag % 10);
        mag = mag / 10;
        nd++;
      end
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.code    = CharW'(CharZero + digit_buf[i]);
      ch.is_last = (i == 0);
      expected_text.push_back(ch);
    end
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        render_decimal(s_axis_tdata_i[ValueW-1:0]);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_text.size() == 0) begin
          note_failure($sformatf("unexpected character tdata=0x%0h tlast=%0b",
                                 m_axis_tdata_i, m_axis_tlast_i));
        end else begin
          want = expected_text.pop_front();
          if (m_axis_tdata_i !== OutDataW'(want.code)) begin
            note_failure($sformatf("character expected 0x%0h got 0x%0h",
                                   OutDataW'(want.code), m_axis_tdata_i));
          end
          if (m_axis_tlast_i !== want.is_last) begin
            note_failure($sformatf("tlast expected %0b got %0b (character 0x%0h)",
                                   want.is_last, m_axis_tlast_i, want.code));
          end
        end
      end
      chars_pending_o <= expected_text.size();
      fail_count_o    <= fail_count;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: stimulus, stall generation and verdict for the ASCII unit.
`timescale 1ns / 1ps

module tb_top;
  import s2da_pkg::*;

  // All block inputs start at known values; reset is held low from time zero.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;  // [31:0] value (signed)
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;        // [5:0] character, [7:6] zero
  logic                m_axis_tlast_o;

  int fail_count;
  int chars_pending;

  signed_to_decimal_ascii_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  s2da_text_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tlast_i  (m_axis_tlast_o),
    .fail_count_o    (fail_count),
    .chars_pending_o (chars_pending)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one so that
  // stalls land on every phase of the serial conversion and the readout.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [ValueW-1:0] pow10(input int k);
    logic [ValueW-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Random values are mostly spread over decimal lengths; only one case in four
  // uses the raw 32-bit range, which would almost always give nine or ten digits.
  function automatic logic [ValueW-1:0] random_value();
    int                ndig;
    logic [ValueW-1:0] lo;
    logic [ValueW-1:0] hi;
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom();
      1: begin
        ndig = $urandom_range(1, 10);
        lo   = (ndig == 1) ? '0 : pow10(ndig - 1);
        hi   = (ndig == 10) ? 32'h7FFF_FFFF : pow10(ndig) - 1;
        v    = lo + $urandom_range(0, hi - lo);
      end
      2: v = $urandom_range(0, 20);
      default: begin
        // Just around a power of ten, where the digit count changes.
        v = pow10($urandom_range(1, 9)) + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Presents one value and returns at the edge at which it was accepted.
  // With a zero gap tvalid simply stays high from the previous transfer.
  task automatic send_value(input logic [ValueW-1:0] v, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InDataW'(v);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Holds the sender off until every predicted character has come out.
  task automatic drain_text();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
  endtask

  // Directed values: zero, single digits, both extremes, several digit count
  // edge and alternating bit patterns.
  logic [ValueW-1:0] directed_values [22] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
    32'd1000000000, 32'd999999999, -32'sd999999999, -32'sd1000000000,
    32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, -32'sd7, 32'd1000000,
    32'hFFFF_FFFE
  };

  // Receiver: bursts of tready separated by random stalls. Now and then a burst
  // is much longer, giving stretches without any backpressure.
  initial begin
    int run_len;
    int gap;
    @(posedge rst_ni);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                            : $urandom_range(1, 8);
      m_axis_tready_i <= 1'b1;
      repeat (run_len) @(posedge clk_i);
      gap = idle_cycles();
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  // Sender and verdict.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_values[i]) send_value(directed_values[i], idle_cycles());
    // Let the directed part drain completely before the random part starts.
    drain_text();

    for (int n = 0; n < 470; n++) begin
      // Items 300 to 359 go back to back to keep the input side saturated.
      send_value(random_value(), (n >= 300 && n < 360) ? 0 : idle_cycles());
      if (n == 200) drain_text();
    end
    drain_text();

    // Idle beyond one item's latency to catch stray characters.
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, long stalls included.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
